[rtl/cltok_pkg.sv]
// Package for the command line tokenizer: record type, codes, sizes and the
// small byte helpers shared by the datapath. Depends on nothing else.
`default_nettype none

package cltok_pkg;

	localparam int CHUNK_CHARS = 8;
	localparam int DELIM_SLOTS = 8;
	localparam int TOKEN_SLOTS = 256;
	localparam int MAX_RECS    = 5;

	localparam logic [7:0] SPACE_CH = 8'h20;
	localparam logic [7:0] QUOTE_CH = 8'h27;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_QUOTED = 2'd1;
	localparam logic [1:0] MODE_AUTO   = 2'd2;

	localparam logic [2:0] KIND_WORD  = 3'd0;
	localparam logic [2:0] KIND_DELIM = 3'd1;
	localparam logic [2:0] KIND_QUOTE = 3'd2;
	localparam logic [2:0] KIND_PATCH = 3'd3;
	localparam logic [2:0] KIND_DONE  = 3'd4;

	localparam logic [2:0] CFG_TOKEN_DELIMS  = 3'd0;
	localparam logic [2:0] CFG_TOKEN_COUNT   = 3'd1;
	localparam logic [2:0] CFG_MSG_DELIMS    = 3'd2;
	localparam logic [2:0] CFG_MSG_COUNT     = 3'd3;
	localparam logic [2:0] CFG_MAX_TOKENS    = 3'd4;

	typedef struct packed {
		logic [7:0]  slot;
		logic [2:0]  kind;
		logic [63:0] text;
		logic [3:0]  text_len;
		logic [15:0] msg_count;
		logic [15:0] chars_used;
		logic        last;
	} rec_t;

	function automatic rec_t mk_rec(input logic [7:0] slot, input logic [2:0] kind,
			input logic [63:0] text, input logic [3:0] len,
			input logic [15:0] cnt, input logic [15:0] used);
		rec_t r;
		r.slot       = slot;
		r.kind       = kind;
		r.text       = text;
		r.text_len   = len;
		r.msg_count  = cnt;
		r.chars_used = used;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] low_bytes(input logic [63:0] v, input logic [3:0] n);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) begin
				r[8*i +: 8] = v[8*i +: 8];
			end
		end
		return r;
	endfunction

	function automatic logic in_list(input logic [7:0] c, input logic [63:0] list,
			input logic [3:0] cnt);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < DELIM_SLOTS; i++) begin
			if (4'(i) < cnt && list[8*i +: 8] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic [63:0] put_byte(input logic [63:0] v, input logic [2:0] idx,
			input logic [7:0] c);
		logic [63:0] r;
		r = v;
		r[{idx, 3'b000} +: 8] = c;
		return r;
	endfunction

	function automatic logic [3:0] clamp_len(input logic [3:0] n);
		return (n > 4'd8) ? 4'd8 : n;
	endfunction

endpackage

`default_nettype wire

[rtl/command_line_tokenizer.sv]
// Command line tokenizer top level: input register, single-pass token logic
// and a five-record result buffer. Depends on cltok_pkg.
//
// Channel  Direction  Signals             Contents
// s_axis   in         tdata[7:0], tuser   char_in; opcode
// m_axis   out        tdata[111:0], tuser, tlast
//                                         slot, text, text_len, msg_count,
//                                         chars_used; kind; last
// cfg      in         cfg_we, cfg_index, cfg_data  register writes
//
// An item is worked once it sits in the input register and the
// result buffer is empty or giving up its final record.
// An item that yields several records holds the output until all are taken;
// items that yield at most one record pass at one per cycle while the output is not stalled.
// The limit on records per item (five) sets the depth of the result buffer.
// Reset clears all tokenizer state and the configuration to its defaults.
// A stalled output holds the current record and, once the input register is
// full, the input side stalls too.
`default_nettype none

module command_line_tokenizer
	import cltok_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // char_in
	input  wire logic         s_axis_tuser,   // opcode
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// slot[7:0], text[71:8], text_len[75:72], msg_count[91:76],
	// chars_used[107:92], zero fill[111:108]
	output logic [111:0]      m_axis_tdata,
	output logic [2:0]        m_axis_tuser,   // kind
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);

	logic [63:0] token_delims_q;
	logic [3:0]  token_delim_count_q;
	logic [63:0] message_delims_q;
	logic [3:0]  message_delim_count_q;
	logic [8:0]  max_tokens_q;

	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  char_s1;

	logic [1:0]  mode_q;
	logic [63:0] chunk_buf_q;
	logic [3:0]  chunk_len_q;
	logic        long_word_q;
	logic [7:0]  prev_char_q;
	logic [8:0]  token_count_q;
	logic [7:0]  count_slot_q;
	logic [15:0] message_chars_q;
	logic [7:0]  close_delim_q;
	logic        stopped_q;
	logic [15:0] consumed_q;

	logic [1:0]  mode_d;
	logic [63:0] chunk_buf_d;
	logic [3:0]  chunk_len_d;
	logic        long_word_d;
	logic [7:0]  prev_char_d;
	logic [8:0]  token_count_d;
	logic [7:0]  count_slot_d;
	logic [15:0] message_chars_d;
	logic [7:0]  close_delim_d;
	logic        stopped_d;
	logic [15:0] consumed_d;

	rec_t        recs_d [MAX_RECS];
	rec_t        rec_q  [MAX_RECS];
	logic [2:0]  n_d;
	logic [2:0]  rec_cnt_q;

	logic        out_take;
	logic        fire;
	logic [8:0]  mt_eff;
	logic [8:0]  lim;
	logic        is_space;
	logic        is_tok;
	logic        is_msg;
	logic        early;
	logic [8:0]  base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_delims_q        <= '0;
			token_delim_count_q   <= '0;
			message_delims_q      <= '0;
			message_delim_count_q <= '0;
			max_tokens_q          <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOKEN_DELIMS: token_delims_q        <= cfg_data;
				CFG_TOKEN_COUNT:  token_delim_count_q   <= cfg_data[3:0];
				CFG_MSG_DELIMS:   message_delims_q      <= cfg_data;
				CFG_MSG_COUNT:    message_delim_count_q <= cfg_data[3:0];
				CFG_MAX_TOKENS:   max_tokens_q          <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = (rec_cnt_q != 3'd0);
	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign fire          = valid_s1 &&
		((rec_cnt_q == 3'd0) || (rec_cnt_q == 3'd1 && out_take));
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tuser;
			char_s1   <= s_axis_tdata;
		end
	end

	always_comb begin
		mt_eff = max_tokens_q;
		if (mt_eff == 9'd0) begin
			mt_eff = 9'd1;
		end
		if (mt_eff > 9'(TOKEN_SLOTS)) begin
			mt_eff = 9'(TOKEN_SLOTS);
		end
		lim = mt_eff - 9'd1;
	end

	always_comb begin
		mode_d          = mode_q;
		chunk_buf_d     = chunk_buf_q;
		chunk_len_d     = chunk_len_q;
		long_word_d     = long_word_q;
		prev_char_d     = prev_char_q;
		token_count_d   = token_count_q;
		count_slot_d    = count_slot_q;
		message_chars_d = message_chars_q;
		close_delim_d   = close_delim_q;
		stopped_d       = stopped_q;
		consumed_d      = consumed_q;
		n_d             = '0;
		early           = 1'b0;
		base            = token_count_q;
		for (int i = 0; i < MAX_RECS; i++) begin
			recs_d[i] = '0;
		end
		is_space = (char_s1 == SPACE_CH);
		is_tok   = in_list(char_s1, token_delims_q, token_delim_count_q);
		is_msg   = in_list(char_s1, message_delims_q, message_delim_count_q);

		if (opcode_s1 == OP_EOS) begin
			if (!stopped_q) begin
				if (chunk_len_d != 4'd0) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
				end
				if (mode_d != MODE_NORMAL) begin
					recs_d[n_d] = mk_rec(count_slot_d, KIND_PATCH, '0, '0,
						(message_chars_d == 16'd0) ? 16'd1 : message_chars_d, '0);
					n_d = n_d + 3'd1;
				end
				recs_d[n_d] = mk_rec('0, KIND_DONE, '0, '0, '0, consumed_d);
				n_d = n_d + 3'd1;
			end
			mode_d          = MODE_NORMAL;
			chunk_buf_d     = '0;
			chunk_len_d     = '0;
			long_word_d     = 1'b0;
			prev_char_d     = SPACE_CH;
			token_count_d   = '0;
			count_slot_d    = '0;
			message_chars_d = '0;
			close_delim_d   = '0;
			stopped_d       = 1'b0;
			consumed_d      = '0;
		end else if (!stopped_q) begin
			if (consumed_d != 16'hFFFF) begin
				consumed_d = consumed_d + 16'd1;
			end

			if ((mode_d == MODE_QUOTED && char_s1 == close_delim_d) ||
					(mode_d == MODE_AUTO && (is_tok || is_space))) begin
				mode_d = MODE_NORMAL;
				if (chunk_len_d != 4'd0) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
					chunk_len_d = '0;
				end
				recs_d[n_d] = mk_rec(count_slot_d, KIND_PATCH, '0, '0,
					(message_chars_d == 16'd0) ? 16'd1 : message_chars_d, '0);
				n_d = n_d + 3'd1;
				if (mode_q == MODE_AUTO && is_tok) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_DELIM,
						{56'd0, char_s1}, 4'd1, '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
				end
			end else if (mode_d != MODE_NORMAL) begin
				chunk_buf_d = put_byte(chunk_buf_d, chunk_len_d[2:0], char_s1);
				chunk_len_d = chunk_len_d + 4'd1;
				if (chunk_len_d >= 4'(CHUNK_CHARS)) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
					chunk_len_d = '0;
				end
				if (message_chars_d != 16'hFFFF) begin
					message_chars_d = message_chars_d + 16'd1;
				end
			end else if (is_space) begin
				if ((prev_char_d != SPACE_CH && chunk_len_d != 4'd0) || long_word_d) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
					chunk_len_d = '0;
					long_word_d = 1'b0;
				end
			end else if (is_tok || is_msg) begin
				if (chunk_len_d != 4'd0) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
					chunk_len_d = '0;
				end
				if (is_tok) begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_DELIM,
						{56'd0, char_s1}, 4'd1, '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = token_count_d + 9'd1;
					long_word_d = 1'b0;
				end else if ({1'b0, token_count_d} + 10'd3 >= {1'b0, lim}) begin
					recs_d[n_d] = mk_rec('0, KIND_DONE, '0, '0, '0, consumed_d);
					n_d = n_d + 3'd1;
					stopped_d = 1'b1;
					early = 1'b1;
				end else begin
					recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_QUOTE,
						{56'd0, char_s1}, 4'd1, '0, '0);
					n_d = n_d + 3'd1;
					mode_d = MODE_QUOTED;
					close_delim_d = char_s1;
					count_slot_d = token_count_d[7:0] + 8'd1;
					token_count_d = token_count_d + 9'd2;
					message_chars_d = '0;
				end
			end else if (long_word_d) begin
				if ({1'b0, token_count_d} + 10'd3 >= {1'b0, lim}) begin
					recs_d[n_d] = mk_rec('0, KIND_DONE, '0, '0, '0, consumed_d);
					n_d = n_d + 3'd1;
					stopped_d = 1'b1;
					early = 1'b1;
				end else begin
					recs_d[n_d] = mk_rec(base[7:0], KIND_QUOTE,
						{56'd0, QUOTE_CH}, 4'd1, '0, '0);
					n_d = n_d + 3'd1;
					recs_d[n_d] = mk_rec(base[7:0] + 8'd2, KIND_WORD,
						low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
						clamp_len(chunk_len_d), '0, '0);
					n_d = n_d + 3'd1;
					token_count_d = base + 9'd3;
					count_slot_d = base[7:0] + 8'd1;
					mode_d = MODE_AUTO;
					chunk_buf_d = put_byte(chunk_buf_d, 3'd0, char_s1);
					chunk_len_d = 4'd1;
					message_chars_d = 16'(CHUNK_CHARS + 1);
					long_word_d = 1'b0;
				end
			end else begin
				chunk_buf_d = put_byte(chunk_buf_d, chunk_len_d[2:0], char_s1);
				chunk_len_d = chunk_len_d + 4'd1;
				if (chunk_len_d >= 4'(CHUNK_CHARS)) begin
					long_word_d = 1'b1;
				end
			end

			if (!early) begin
				prev_char_d = char_s1;
				if (token_count_d >= lim) begin
					if (chunk_len_d != 4'd0) begin
						recs_d[n_d] = mk_rec(token_count_d[7:0], KIND_WORD,
							low_bytes(chunk_buf_d, clamp_len(chunk_len_d)),
							clamp_len(chunk_len_d), '0, '0);
						n_d = n_d + 3'd1;
						token_count_d = token_count_d + 9'd1;
						chunk_len_d = '0;
					end
					if (mode_d != MODE_NORMAL) begin
						recs_d[n_d] = mk_rec(count_slot_d, KIND_PATCH, '0, '0,
							(message_chars_d == 16'd0) ? 16'd1 : message_chars_d, '0);
						n_d = n_d + 3'd1;
					end
					recs_d[n_d] = mk_rec('0, KIND_DONE, '0, '0, '0, consumed_d);
					n_d = n_d + 3'd1;
					stopped_d = 1'b1;
				end
			end
		end

		if (n_d != 3'd0) begin
			recs_d[n_d - 3'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_NORMAL;
			chunk_buf_q     <= '0;
			chunk_len_q     <= '0;
			long_word_q     <= 1'b0;
			prev_char_q     <= SPACE_CH;
			token_count_q   <= '0;
			count_slot_q    <= '0;
			message_chars_q <= '0;
			close_delim_q   <= '0;
			stopped_q       <= 1'b0;
			consumed_q      <= '0;
		end else if (fire) begin
			mode_q          <= mode_d;
			chunk_buf_q     <= chunk_buf_d;
			chunk_len_q     <= chunk_len_d;
			long_word_q     <= long_word_d;
			prev_char_q     <= prev_char_d;
			token_count_q   <= token_count_d;
			count_slot_q    <= count_slot_d;
			message_chars_q <= message_chars_d;
			close_delim_q   <= close_delim_d;
			stopped_q       <= stopped_d;
			consumed_q      <= consumed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_cnt_q <= '0;
		end else if (fire) begin
			rec_cnt_q <= n_d;
		end else if (out_take) begin
			rec_cnt_q <= rec_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_RECS; i++) begin
				rec_q[i] <= recs_d[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < MAX_RECS - 1; i++) begin
				rec_q[i] <= rec_q[i + 1];
			end
		end
	end

	assign m_axis_tdata = {4'd0, rec_q[0].chars_used, rec_q[0].msg_count,
		rec_q[0].text_len, rec_q[0].text, rec_q[0].slot};
	assign m_axis_tuser = rec_q[0].kind;
	assign m_axis_tlast = rec_q[0].last;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_cnt_q <= 3'(MAX_RECS))
		else $error("result buffer count out of range");

	a_last_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> rec_cnt_q == 3'd1)
		else $error("last record is not the final buffered record");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
		else $error("done record not marked last");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && stopped_q && opcode_s1 == OP_CHAR |=> rec_cnt_q == 3'd0)
		else $error("records produced after the stop");

	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_len_q <= 4'(CHUNK_CHARS))
		else $error("chunk length exceeds chunk size");

endmodule

`default_nettype wire
